// ===== rtl/ucf_pkg.sv =====
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared types and constants of the UTF-8 Cyrillic case fold block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucf_pkg;

  localparam int UCF_ADDR_W = 3;
  localparam logic REG_FOLD_TO_UPPER = 1'b0;

  localparam logic [7:0] LEAD_D0     = 8'hD0;
  localparam logic [7:0] LEAD_D1     = 8'hD1;
  localparam logic [7:0] CASE_DELTA  = 8'h20;
  localparam logic [7:0] YO_UP_TRAIL = 8'h81;
  localparam logic [7:0] YO_LO_TRAIL = 8'h91;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ucf_word_t;

  typedef struct packed {
    logic [1:0] num;
    ucf_word_t  w0;
    ucf_word_t  w1;
  } ucf_push_t;

endpackage

// ===== rtl/utf8_cyrillic_case_fold.sv =====
// ----------------------------------------------------------------------------
// utf8_cyrillic_case_fold
// Upper/lower case conversion of a UTF-8 byte stream, ASCII and Cyrillic.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one word per handshake: in_byte and
// in_last. Output channel out_valid/out_ready delivers one word per handshake:
// out_byte and out_last, same count and order as the input. A D0/D1 lead byte
// not marked last is held and leaves together with its trail byte.
// The APB port writes fold_to_upper at address 0 (1 upper, 0 lower); write it
// only while the stream is idle.
// An accepted word passes through the input register and the fold logic into
// the result queue before it appears; a held lead appears with its trail.
// Throughput: one word per cycle in and out unless the receiver stalls, set
// by the single fold stage feeding a four-word result queue that absorbs the
// two-word pair bursts. Reset clears the held lead, the queue and fold_to_upper.
// When the receiver stalls the queue fills; in_ready drops once the input
// register holds a word and fewer than two queue entries are free, and
// recovers as soon as words drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_cyrillic_case_fold
  import ucf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [UCF_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic      fold_to_upper_r;
  logic      fold_to_upper_nxt;
  logic      cfg_sel;
  logic      space;
  logic      word_valid;
  ucf_word_t word;
  ucf_push_t push;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[UCF_ADDR_W-1] == REG_FOLD_TO_UPPER;
  assign cfg_prdata = cfg_sel ? {31'd0, fold_to_upper_r} : 32'd0;
  assign fold_to_upper_nxt =
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel) ?
    cfg_pwdata[0] : fold_to_upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_to_upper_r <= 1'b0;
    end else begin
      fold_to_upper_r <= fold_to_upper_nxt;
    end
  end

  ucf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .advance    (space),
    .word_valid (word_valid),
    .word       (word)
  );

  ucf_fold u_fold (
    .clk           (clk),
    .rst_n         (rst_n),
    .fold_to_upper (fold_to_upper_r),
    .word_valid    (word_valid),
    .word          (word),
    .advance       (space),
    .push          (push)
  );

  ucf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/ucf_in_reg.sv =====
// ----------------------------------------------------------------------------
// ucf_in_reg
// Input register stage: captures one word and holds it until it advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucf_in_reg
  import ucf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       word_valid,
  output ucf_word_t  word
);

  logic      valid_r;
  logic      valid_nxt;
  ucf_word_t word_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r.data <= in_byte;
      word_r.last <= in_last;
    end
  end

endmodule

// ===== rtl/ucf_fold.sv =====
// ----------------------------------------------------------------------------
// ucf_fold
// Case fold logic: ASCII letters, held D0/D1 lead and Cyrillic pair rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucf_fold
  import ucf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fold_to_upper,
  input  logic      word_valid,
  input  ucf_word_t word,
  input  logic      advance,
  output ucf_push_t push
);

  logic       held_r;
  logic       held_nxt;
  logic       d1_r;
  logic       d1_nxt;
  logic [7:0] lead;
  logic [7:0] trail;
  logic [7:0] b;
  logic [7:0] ascii_out;

  assign b = word.data;

  always_comb begin
    ascii_out = b;
    if (fold_to_upper) begin
      if (b inside {[8'h61:8'h7A]}) ascii_out = b - CASE_DELTA;
    end else begin
      if (b inside {[8'h41:8'h5A]}) ascii_out = b + CASE_DELTA;
    end
  end

  always_comb begin
    lead  = d1_r ? LEAD_D1 : LEAD_D0;
    trail = b;
    if (fold_to_upper) begin
      if (!d1_r && (b inside {[8'hB0:8'hBF]})) begin
        trail = b - CASE_DELTA;
      end else if (d1_r && (b inside {[8'h80:8'h8F]})) begin
        lead  = LEAD_D0;
        trail = b + CASE_DELTA;
      end else if (d1_r && b == YO_LO_TRAIL) begin
        lead  = LEAD_D0;
        trail = YO_UP_TRAIL;
      end
    end else begin
      if (!d1_r && (b inside {[8'h90:8'h9F]})) begin
        trail = b + CASE_DELTA;
      end else if (!d1_r && (b inside {[8'hA0:8'hAF]})) begin
        lead  = LEAD_D1;
        trail = b - CASE_DELTA;
      end else if (!d1_r && b == YO_UP_TRAIL) begin
        lead  = LEAD_D1;
        trail = YO_LO_TRAIL;
      end
    end
  end

  always_comb begin
    held_nxt     = held_r;
    d1_nxt       = d1_r;
    push.num     = 2'd0;
    push.w0.data = ascii_out;
    push.w0.last = word.last;
    push.w1.data = trail;
    push.w1.last = word.last;
    if (word_valid && advance) begin
      if (held_r) begin
        push.num     = 2'd2;
        push.w0.data = lead;
        push.w0.last = 1'b0;
        held_nxt     = 1'b0;
        d1_nxt       = 1'b0;
      end else if ((b == LEAD_D0 || b == LEAD_D1) && !word.last) begin
        held_nxt = 1'b1;
        d1_nxt   = (b == LEAD_D1);
      end else begin
        push.num = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      d1_r   <= 1'b0;
    end else begin
      held_r <= held_nxt;
      d1_r   <= d1_nxt;
    end
  end

endmodule

// ===== rtl/ucf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ucf_out_fifo
// Result queue: takes up to two words a cycle, delivers one word a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucf_out_fifo
  import ucf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ucf_push_t  push,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ucf_word_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign space      = count_r <= (PTR_W+1)'(DEPTH - 2);
  assign out_valid  = count_r != '0;
  assign pop        = out_valid && out_ready;
  assign out_byte   = mem_r[rd_ptr_r].data;
  assign out_last   = mem_r[rd_ptr_r].last;
  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.num);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + (PTR_W+1)'(push.num) - (PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.w0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.w1;
    end
  end

endmodule

// ===== tb/utf8_cyrillic_case_fold_test.sv =====
// ----------------------------------------------------------------------------
// utf8_cyrillic_case_fold_test
// Self-checking bench for the UTF-8 ASCII/Cyrillic case fold block.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a valid/ready driver. Every accepted word runs
// through a local case-fold predictor that keeps its own copy of the held lead
// byte and of the fold direction. The output monitor compares each delivered
// word, byte and last flag, against the oldest predicted word. A directed part
// covers ASCII bounds, every Cyrillic pair rule, non-letter trails, a lone final
// lead and a mode change while a lead is held. Random strings follow, over
// phases with both fold directions, random idling on both sides and one long
// receiver stall that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_cyrillic_case_fold_test;
  import ucf_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_WORDS  = 240;
  localparam logic [UCF_ADDR_W-1:0] FOLD_MODE_ADDR = UCF_ADDR_W'(REG_FOLD_TO_UPPER) << 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte = 8'h00;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_last;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [UCF_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = 32'h0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  ucf_word_t   byte_send_q[$];
  ucf_word_t   fold_expect_q[$];

  logic        fold_up_q = 1'b0;
  logic        lead_pending = 1'b0;
  logic        lead_pending_d1 = 1'b0;

  logic        in_accepted = 1'b0;
  logic        out_accepted = 1'b0;
  logic        send_calm = 1'b1;
  logic        recv_calm = 1'b1;
  logic        hold_req = 1'b0;
  int          send_wait = 0;
  int          recv_wait = 0;
  int          words_queued = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  utf8_cyrillic_case_fold u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait(input logic calm);
    if (calm) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic push_expected(input logic [7:0] b, input logic last);
    ucf_word_t w;
    w.data = b;
    w.last = last;
    fold_expect_q.insert(fold_expect_q.size(), w);
  endtask

  task automatic predict_fold(input logic [7:0] b, input logic last);
    logic [7:0] lead;
    logic [7:0] trail;
    logic [7:0] folded;
    if (lead_pending) begin
      lead  = lead_pending_d1 ? LEAD_D1 : LEAD_D0;
      trail = b;
      if (fold_up_q) begin
        if (lead == LEAD_D0 && b >= 8'hB0 && b <= 8'hBF) begin
          trail = b - CASE_DELTA;
        end else if (lead == LEAD_D1 && b >= 8'h80 && b <= 8'h8F) begin
          lead  = LEAD_D0;
          trail = b + CASE_DELTA;
        end else if (lead == LEAD_D1 && b == YO_LO_TRAIL) begin
          lead  = LEAD_D0;
          trail = YO_UP_TRAIL;
        end
      end else begin
        if (lead == LEAD_D0 && b >= 8'h90 && b <= 8'h9F) begin
          trail = b + CASE_DELTA;
        end else if (lead == LEAD_D0 && b >= 8'hA0 && b <= 8'hAF) begin
          lead  = LEAD_D1;
          trail = b - CASE_DELTA;
        end else if (lead == LEAD_D0 && b == YO_UP_TRAIL) begin
          lead  = LEAD_D1;
          trail = YO_LO_TRAIL;
        end
      end
      lead_pending    = 1'b0;
      lead_pending_d1 = 1'b0;
      push_expected(lead, 1'b0);
      push_expected(trail, last);
    end else if ((b == LEAD_D0 || b == LEAD_D1) && !last) begin
      lead_pending    = 1'b1;
      lead_pending_d1 = (b == LEAD_D1);
    end else begin
      folded = b;
      if (fold_up_q && b >= 8'h61 && b <= 8'h7A) folded = b - CASE_DELTA;
      if (!fold_up_q && b >= 8'h41 && b <= 8'h5A) folded = b + CASE_DELTA;
      push_expected(folded, last);
    end
  endtask

  // sample both channels; check delivered words, predict accepted ones
  always @(posedge clk) begin : sample
    ucf_word_t want;
    in_accepted  = rst_n && in_valid && in_ready;
    out_accepted = rst_n && out_valid && out_ready;
    if (out_accepted) begin
      if (fold_expect_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                 $time, out_byte, out_last);
        mismatches++;
      end else begin
        want = fold_expect_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.data, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
          mismatches++;
        end
      end
    end
    if (in_accepted) predict_fold(in_byte, in_last);
  end

  // drive input words; hold the word until it is taken
  always @(negedge clk) begin : drive
    ucf_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (byte_send_q.size() != 0) begin
        nxt = byte_send_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nxt.data;
        in_last  <= nxt.last;
        send_wait = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // drive the receiver side stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_accepted) recv_wait = draw_wait(recv_calm);
      if (hold_req) begin
        recv_wait = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    ucf_word_t w;
    w.data = b;
    w.last = last;
    byte_send_q.insert(byte_send_q.size(), w);
    words_queued++;
  endtask

  task automatic queue_random_string();
    int         len;
    int         kind;
    logic       fin;
    logic       mark;
    logic [7:0] lead;
    logic [7:0] trail;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      fin  = (i == len - 1);
      mark = fin || ($urandom_range(0, 31) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        lead = $urandom_range(0, 1) ? LEAD_D1 : LEAD_D0;
        if ($urandom_range(0, 7) == 0) trail = 8'($urandom_range(0, 255));
        else trail = 8'($urandom_range(8'h80, 8'hBF));
        if (fin && $urandom_range(0, 7) == 0) begin
          queue_word(lead, 1'b1);
        end else begin
          queue_word(lead, 1'b0);
          queue_word(trail, mark);
        end
      end else if (kind < 7) begin
        if ($urandom_range(0, 1)) queue_word(8'($urandom_range(8'h41, 8'h5A)), mark);
        else queue_word(8'($urandom_range(8'h61, 8'h7A)), mark);
      end else if (kind < 8) begin
        queue_word(8'($urandom_range(0, 8'h7F)), mark);
      end else begin
        queue_word(8'($urandom_range(0, 255)), mark);
      end
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (byte_send_q.size() != 0 || in_valid || fold_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fold_mode(input logic up);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FOLD_MODE_ADDR;
    cfg_pwdata  <= {31'h0, up};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    fold_up_q = up;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lower case from the reset value of the mode
    queue_word(8'h41, 1'b0);
    queue_word(8'h5A, 1'b0);
    queue_word(8'h5B, 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b1);
    queue_word(LEAD_D0, 1'b0);
    queue_word(8'h90, 1'b0);
    queue_word(LEAD_D0, 1'b0);
    queue_word(8'hAF, 1'b0);
    queue_word(LEAD_D0, 1'b0);
    queue_word(YO_UP_TRAIL, 1'b0);
    queue_word(LEAD_D0, 1'b0);
    queue_word(8'h5A, 1'b1);
    queue_word(LEAD_D1, 1'b1);
    // leave a lead held across the mode change
    queue_word(LEAD_D0, 1'b0);
    wait_idle();

    write_fold_mode(1'b1);
    queue_word(8'hB5, 1'b0);
    queue_word(8'h61, 1'b0);
    queue_word(8'h7A, 1'b1);
    queue_word(LEAD_D0, 1'b0);
    queue_word(8'hBF, 1'b0);
    queue_word(LEAD_D1, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_word(LEAD_D1, 1'b0);
    queue_word(YO_LO_TRAIL, 1'b0);
    queue_word(LEAD_D1, 1'b0);
    queue_word(LEAD_D0, 1'b1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 2) write_fold_mode(p[0]);
      else write_fold_mode(1'($urandom_range(0, 1)));
      send_calm = ($urandom_range(0, 2) == 0);
      recv_calm = ($urandom_range(0, 2) == 0);
      if (p == 2) begin
        send_calm = 1'b1;
        hold_req  = 1'b1;
      end
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) queue_random_string();
      if ($urandom_range(0, 3) == 0) queue_word($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0, 1'b0);
      wait_idle();
    end

    if (mismatches == 0 && fold_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ucf_pkg.sv
rtl/ucf_in_reg.sv
rtl/ucf_fold.sv
rtl/ucf_out_fifo.sv
rtl/utf8_cyrillic_case_fold.sv
tb/utf8_cyrillic_case_fold_test.sv
